FILE: hw/rtl/decimal_digit_multiplier_macros.svh
// assertion macros shared by the decimal digit multiplier rtl
// depends on nothing; included by files that hold concurrent checks
`ifndef DECIMAL_DIGIT_MULTIPLIER_MACROS_SVH
`define DECIMAL_DIGIT_MULTIPLIER_MACROS_SVH

// same-cycle implication
`define DDM_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication
`define DDM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: hw/rtl/ddm_pkg.sv
// shared types and constants of the decimal digit multiplier
// depends on nothing
`timescale 1ns / 1ps

package ddm_pkg;

    localparam int IN_W        = 31;
    localparam int BIT_W       = $clog2(IN_W);
    localparam int DIGIT_W     = 4;
    localparam int RADIX       = 10;
    localparam int MAX_OUT     = 20;
    localparam int OUT_IDX_W   = $clog2(MAX_OUT);
    localparam int RECIP_MUL   = 52429;
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W     = 16;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 8;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef struct packed {
        logic acc_clr;
        logic mac_en;
        logic resolve;
    } col_ctrl_t;

    typedef struct packed {
        digit_t digit;
        logic   nonzero;
    } col_stat_t;

endpackage

FILE: hw/rtl/decimal_digit_multiplier.sv
// top level of the decimal digit multiplier: sequencer, digit buffers, output register
// depends on ddm_pkg, ddm_bin2bcd, ddm_col_unit and decimal_digit_multiplier_macros.svh
`timescale 1ns / 1ps
//
// Usage
//   slave channel s_*: one transaction carries both operands; s_tready is high only
//   while the block is idle. master channel m_*: one transaction per product digit,
//   most significant first, leading zeros stripped, m_tlast on the final digit; a zero
//   product gives a single 0 with m_tlast.
//   Sequence (D = OPERAND_DIGITS): bit-serial bcd conversion of both operands, then
//   accumulation of the D*D digit products through the one shared multiplier,
//   interleaved with the resolve of each of the 2*D+2 columns; the sequencer then
//   enters the emit state and loads the first digit into the output register, and
//   further digits follow one per cycle while m_tready is high.
//   A new operand pair is taken only once the final digit has been loaded.
//   The final digit sits in the output register while the next operand pair is taken.
//   A stall on m_tready freezes digit emission; nothing is dropped.
//   Reset (rst_n low, asynchronous) returns the sequencer to idle and clears m_tvalid.
//
`include "decimal_digit_multiplier_macros.svh"

module decimal_digit_multiplier
    import ddm_pkg::*;
#(
    parameter int OPERAND_DIGITS = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [30:0] multiplicand, [61:31] multiplier, [63:62] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [3:0] digit, [7:4] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int D       = OPERAND_DIGITS;
    localparam int COLS    = 2 * D + 2;
    localparam int K_W     = $clog2(COLS);
    localparam int IDX_W   = (D > 1) ? $clog2(D) : 1;
    localparam int ACC_RAW = $clog2(90 * D + 1);
    localparam int ACC_W   = (ACC_RAW < 2 * DIGIT_W) ? 2 * DIGIT_W : ACC_RAW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_MAC  = 3'd2;
    localparam logic [2:0] ST_RES  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [BIT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [K_W-1:0]       k_reg, k_next;
    logic [K_W-1:0]       i_reg, i_next;
    logic [OUT_IDX_W-1:0] top_reg, top_next;
    logic                 hi_nz_reg, hi_nz_next;
    logic [OUT_IDX_W-1:0] idx_reg, idx_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    digit_t               m_digit_reg;
    logic                 m_last_reg;
    digit_t               res_reg [MAX_OUT];

    logic                 accept;
    logic                 emit_load;
    logic                 res_wr;
    logic                 k_low;
    logic [K_W-1:0]       k_inc;
    logic [K_W-1:0]       j_idx;
    logic [OUT_IDX_W-1:0] top_upd;
    logic                 hi_nz_upd;
    logic [OUT_IDX_W-1:0] top_final;

    logic [D*DIGIT_W-1:0] bcd_a;
    logic [D*DIGIT_W-1:0] bcd_b;
    digit_t               a_digit;
    digit_t               b_digit;
    col_ctrl_t            col_ctrl;
    col_stat_t            col_stat;

    function automatic logic [K_W-1:0] col_lo(input logic [K_W-1:0] k);
        return (k > K_W'(D - 1)) ? k - K_W'(D - 1) : '0;
    endfunction

    function automatic logic [K_W-1:0] col_hi(input logic [K_W-1:0] k);
        return (k < K_W'(D)) ? k : K_W'(D - 1);
    endfunction

    function automatic logic col_has_terms(input logic [K_W-1:0] k);
        return k <= K_W'(2 * D - 2);
    endfunction

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign emit_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    ddm_bin2bcd #(.DIGITS(D)) u_conv_a
    (
        .clk   (clk),
        .load  (accept),
        .shift (state_reg == ST_CONV),
        .value (s_tdata[IN_W-1:0]),
        .bcd   (bcd_a)
    );

    ddm_bin2bcd #(.DIGITS(D)) u_conv_b
    (
        .clk   (clk),
        .load  (accept),
        .shift (state_reg == ST_CONV),
        .value (s_tdata[2*IN_W-1:IN_W]),
        .bcd   (bcd_b)
    );

    assign j_idx   = k_reg - i_reg;
    assign a_digit = bcd_a[i_reg[IDX_W-1:0]*DIGIT_W +: DIGIT_W];
    assign b_digit = bcd_b[j_idx[IDX_W-1:0]*DIGIT_W +: DIGIT_W];

    assign col_ctrl.acc_clr = accept;
    assign col_ctrl.mac_en  = (state_reg == ST_MAC);
    assign col_ctrl.resolve = (state_reg == ST_RES);

    ddm_col_unit #(.ACC_W(ACC_W)) u_col
    (
        .clk     (clk),
        .ctrl    (col_ctrl),
        .a_digit (a_digit),
        .b_digit (b_digit),
        .stat    (col_stat)
    );

    // columns past the output limit only feed the leading-digit clamp
    assign k_low     = (int'(k_reg) < MAX_OUT);
    assign res_wr    = (state_reg == ST_RES) && k_low;
    assign top_upd   = (col_stat.nonzero && k_low) ? OUT_IDX_W'(k_reg) : top_reg;
    assign hi_nz_upd = hi_nz_reg | (col_stat.nonzero && !k_low);
    assign top_final = hi_nz_upd ? OUT_IDX_W'(MAX_OUT - 1) : top_upd;
    assign k_inc     = k_reg + K_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        bit_cnt_next  = bit_cnt_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        top_next      = top_reg;
        hi_nz_next    = hi_nz_reg;
        idx_next      = idx_reg;
        m_tvalid_next = (m_tvalid_reg && m_tready) ? 1'b0 : m_tvalid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next   = ST_CONV;
                    bit_cnt_next = '0;
                    top_next     = '0;
                    hi_nz_next   = 1'b0;
                end
            end
            ST_CONV:
            begin
                bit_cnt_next = bit_cnt_reg + BIT_W'(1);
                if (bit_cnt_reg == BIT_W'(IN_W - 1))
                begin
                    state_next = ST_MAC;
                    k_next     = '0;
                    i_next     = '0;
                end
            end
            ST_MAC:
            begin
                if (i_reg == col_hi(k_reg))
                    state_next = ST_RES;
                else
                    i_next = i_reg + K_W'(1);
            end
            ST_RES:
            begin
                top_next   = top_upd;
                hi_nz_next = hi_nz_upd;
                if (k_reg == K_W'(COLS - 1))
                begin
                    state_next = ST_EMIT;
                    idx_next   = top_final;
                end
                else
                begin
                    k_next = k_inc;
                    i_next = col_lo(k_inc);
                    state_next = col_has_terms(k_inc) ? ST_MAC : ST_RES;
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    m_tvalid_next = 1'b1;
                    if (idx_reg == '0)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg - OUT_IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bit_cnt_reg  <= '0;
            k_reg        <= '0;
            i_reg        <= '0;
            top_reg      <= '0;
            hi_nz_reg    <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bit_cnt_reg  <= bit_cnt_next;
            k_reg        <= k_next;
            i_reg        <= i_next;
            top_reg      <= top_next;
            hi_nz_reg    <= hi_nz_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_wr)
            res_reg[OUT_IDX_W'(k_reg)] <= col_stat.digit;
        if (emit_load)
        begin
            m_digit_reg <= res_reg[idx_reg];
            m_last_reg  <= (idx_reg == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-DIGIT_W){1'b0}}, m_digit_reg};
    assign m_tlast  = m_last_reg;

    `DDM_ASSERT_NEXT(a_accept_starts_conv, clk, rst_n, accept, state_reg == ST_CONV)
    `DDM_ASSERT_NEXT(a_stall_holds_emit, clk, rst_n,
        (state_reg == ST_EMIT) && m_tvalid_reg && !m_tready,
        (state_reg == ST_EMIT) && $stable(idx_reg))
    `DDM_ASSERT_NOW(a_resolved_digit_decimal, clk, rst_n, state_reg == ST_RES,
        col_stat.digit <= 4'd9)

endmodule

FILE: hw/rtl/ddm_bin2bcd.sv
// shift-and-add-3 binary to bcd converter, one input bit per cycle while shift is high
// depends on ddm_pkg
`timescale 1ns / 1ps

module ddm_bin2bcd
    import ddm_pkg::*;
#(
    parameter int DIGITS = 10
)
(
    input  logic                        clk,
    input  logic                        load,
    input  logic                        shift,
    input  logic [IN_W-1:0]             value,
    output logic [DIGITS*DIGIT_W-1:0]   bcd
);

    logic [IN_W-1:0]           bin_reg;
    logic [IN_W-1:0]           bin_next;
    logic [DIGITS*DIGIT_W-1:0] bcd_reg;
    logic [DIGITS*DIGIT_W-1:0] bcd_next;
    logic [DIGITS*DIGIT_W-1:0] adj;

    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[d*DIGIT_W +: DIGIT_W] >= 4'd5)
                adj[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W] + 4'd3;
            else
                adj[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W];
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (load)
        begin
            bin_next = value;
            bcd_next = '0;
        end
        else if (shift)
        begin
            bin_next = {bin_reg[IN_W-2:0], 1'b0};
            // carry out of the top digit falls off: value modulo 10^DIGITS
            bcd_next = {adj[DIGITS*DIGIT_W-2:0], bin_reg[IN_W-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign bcd = bcd_reg;

endmodule

FILE: hw/rtl/ddm_col_unit.sv
// shared digit multiply-accumulate and decimal carry resolve unit
// depends on ddm_pkg
`timescale 1ns / 1ps

module ddm_col_unit
    import ddm_pkg::*;
#(
    parameter int ACC_W = 11
)
(
    input  logic      clk,
    input  col_ctrl_t ctrl,
    input  digit_t    a_digit,
    input  digit_t    b_digit,
    output col_stat_t stat
);

    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic [ACC_W-1:0]         carry_reg;
    logic [ACC_W-1:0]         carry_next;
    logic [2*DIGIT_W-1:0]     prod;
    logic [ACC_W-1:0]         col_sum;
    logic [ACC_W+RECIP_W-1:0] q_mul;
    logic [ACC_W-1:0]         quot;
    logic [ACC_W-1:0]         rem;

    assign prod    = {{DIGIT_W{1'b0}}, a_digit} * {{DIGIT_W{1'b0}}, b_digit};
    assign col_sum = acc_reg + carry_reg;

    // divide by ten through the reciprocal, exact far beyond the column range
    assign q_mul = {{RECIP_W{1'b0}}, col_sum} * (ACC_W+RECIP_W)'(RECIP_MUL);
    assign quot  = ACC_W'(q_mul >> RECIP_SHIFT);
    assign rem   = col_sum - ((quot << 3) + (quot << 1));

    always_comb
    begin
        acc_next   = acc_reg;
        carry_next = carry_reg;
        priority if (ctrl.acc_clr)
        begin
            acc_next   = '0;
            carry_next = '0;
        end
        else if (ctrl.mac_en)
        begin
            acc_next = acc_reg + ACC_W'(prod);
        end
        else if (ctrl.resolve)
        begin
            acc_next   = '0;
            carry_next = quot;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        carry_reg <= carry_next;
    end

    assign stat.digit   = rem[DIGIT_W-1:0];
    assign stat.nonzero = (rem != '0);

endmodule

FILE: sim/tb.sv
// self-checking testbench for decimal_digit_multiplier: directed table, then random operand pairs
// depends on ddm_pkg and the decimal_digit_multiplier rtl
`timescale 1ns / 1ps

module tb;

    import ddm_pkg::*;

    typedef struct {
        digit_t digit;
        logic   last;
    } product_digit_t;

    typedef struct {
        logic [IN_W-1:0] multiplicand;
        logic [IN_W-1:0] multiplier;
        bit              typed;
        longint unsigned product;
    } operand_row_t;

    localparam logic [IN_W-1:0] OPERAND_MAX = {IN_W{1'b1}};

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    product_digit_t pending_digits[$];
    product_digit_t oldest_digit;
    int             check_failures = 0;
    bit             idle_on = 1'b0;
    int             hold_cycles = 0;

    // directed rows; product typed in where it is obvious, else predicted
    operand_row_t directed_rows [18] = '{
        '{31'd0,          31'd0,          1'b1, 64'd0},
        '{31'd0,          OPERAND_MAX,    1'b1, 64'd0},
        '{OPERAND_MAX,    31'd0,          1'b1, 64'd0},
        '{31'd1,          31'd1,          1'b1, 64'd1},
        '{OPERAND_MAX,    31'd1,          1'b1, 64'd2147483647},
        '{31'd1,          OPERAND_MAX,    1'b1, 64'd2147483647},
        '{OPERAND_MAX,    OPERAND_MAX,    1'b1, 64'd4611686014132420609},
        '{31'd9,          31'd9,          1'b1, 64'd81},
        '{31'd10,         31'd10,         1'b1, 64'd100},
        '{31'd1000000000, 31'd1000000000, 1'b1, 64'd1000000000000000000},
        '{31'd999999999,  31'd999999999,  1'b0, 64'd0},
        '{31'd2000000000, 31'd1999999999, 1'b0, 64'd0},
        '{31'h55555555,   31'h2aaaaaaa,   1'b0, 64'd0},
        '{31'h2aaaaaaa,   31'h55555555,   1'b0, 64'd0},
        '{31'd7,          31'd1000000000, 1'b0, 64'd0},
        '{31'd123456789,  31'd987654321,  1'b0, 64'd0},
        '{31'd5,          31'd2,          1'b1, 64'd10},
        '{31'd1,          31'd0,          1'b1, 64'd0}
    };

    decimal_digit_multiplier uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // full product of two 31-bit operands always fits in 64 bits
    function automatic longint unsigned predicted_product(input logic [IN_W-1:0] a,
                                                          input logic [IN_W-1:0] b);
        return longint'(a) * longint'(b);
    endfunction

    // queue product digits most significant first, zero gives a single 0
    task automatic queue_product_digits(input longint unsigned product);
        digit_t         digits[$];
        product_digit_t entry;
        longint unsigned rest;
        rest = product;
        do
        begin
            digits.push_front(digit_t'(rest % RADIX));
            rest = rest / RADIX;
        end
        while (rest != 0);
        foreach (digits[i])
        begin
            entry.digit = digits[i];
            entry.last  = (i == digits.size() - 1);
            pending_digits.push_back(entry);
        end
    endtask

    function automatic logic [IN_W-1:0] random_operand();
        logic [IN_W-1:0] value;
        longint unsigned power;
        int              k;
        power = 1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: value = IN_W'($urandom);
            5: value = IN_W'($urandom_range(0, 99));
            6:
            begin
                k = $urandom_range(0, 9);
                repeat (k) power = power * RADIX;
                value = IN_W'(power * $urandom_range(1, 2));
            end
            7: value = '0;
            8:
            begin
                k = $urandom_range(1, 9);
                repeat (k) power = power * RADIX;
                value = IN_W'(power - 1);
            end
            default: value = OPERAND_MAX - IN_W'($urandom_range(0, 15));
        endcase
        return value;
    endfunction

    task automatic send_pair(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b,
                             input bit typed, input longint unsigned typed_product);
        int gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 2 * IN_W){1'b0}}, b, a};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        queue_product_digits(typed ? typed_product : predicted_product(a, b));
    endtask

    task automatic send_random_pairs(input int count);
        repeat (count) send_pair(random_operand(), random_operand(), 1'b0, 64'd0);
    endtask

    // stimulus
    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_pair(directed_rows[i].multiplicand, directed_rows[i].multiplier,
                      directed_rows[i].typed, directed_rows[i].product);

        // let the block drain completely before going random
        s_tvalid <= 1'b0;
        while (pending_digits.size() != 0) @(posedge clk);

        idle_on = 1'b1;
        send_random_pairs(64);

        // receiver stalls for a long stretch while pairs keep coming
        idle_on     = 1'b0;
        hold_cycles = 600;
        send_random_pairs(64);

        idle_on = 1'b1;
        send_random_pairs(64);

        s_tvalid <= 1'b0;
        while (pending_digits.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        if (check_failures == 0 && pending_digits.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // receiver with random stalls
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            gap = idle_on ? $urandom_range(0, 12) : 0;
            if (hold_cycles > 0)
            begin
                gap         = hold_cycles;
                hold_cycles = 0;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // compare each output transaction with the oldest predicted digit
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_digits.size() == 0)
            begin
                $error("unexpected digit %0d, last %0b", m_tdata[DIGIT_W-1:0], m_tlast);
                check_failures++;
            end
            else
            begin
                oldest_digit = pending_digits.pop_front();
                if (m_tdata[DIGIT_W-1:0] !== oldest_digit.digit)
                begin
                    $error("digit: expected %0d, actual %0d",
                           oldest_digit.digit, m_tdata[DIGIT_W-1:0]);
                    check_failures++;
                end
                if (m_tlast !== oldest_digit.last)
                begin
                    $error("last_digit: expected %0b, actual %0b", oldest_digit.last, m_tlast);
                    check_failures++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ddm_pkg.sv
hw/rtl/ddm_bin2bcd.sv
hw/rtl/ddm_col_unit.sv
hw/rtl/decimal_digit_multiplier.sv
sim/tb.sv
